FILE: design/rcmv_pkg.sv
// ----------------------------------------------------------------------------
// rcmv_pkg: shared types for the rod cutting solver
// Field widths, operation and result codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rcmv_pkg;

	localparam int LEN_W   = 6;
	localparam int PRICE_W = 16;
	localparam int VALUE_W = 21;
	// A price plus a best total, one bit wider than a stored total.
	localparam int SUM_W   = 22;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_PIECE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [LEN_W-1:0]   length;
		logic [PRICE_W-1:0] price;
	} req_t;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRITE,
		S_VAL_RD,
		S_VAL_EMIT,
		S_CUT_RD,
		S_CUT_EMIT
	} state_t;

	typedef struct packed {
		logic load_price;
		logic start;
		logic scan_issue;
		logic row_write;
		logic val_read;
		logic val_emit;
		logic cut_read;
		logic cut_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_zero;
		logic j_last;
		logic i_last;
		logic n_zero;
		logic rem_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: design/rod_cutting_max_value.sv
// ----------------------------------------------------------------------------
// rod_cutting_max_value: best price cut of a rod
// Price loads and rod solves on one request channel; the total and the cut
// pieces leave on the response channel.
// ----------------------------------------------------------------------------
// Usage. A request with operation load stores the price of one piece length
// and is stored when it is taken; a length above MAX_LEN is dropped. A request
// with operation solve fills the best and cut tables for rows 1..n (n is
// saturated to MAX_LEN) and then sends one transfer with the best total,
// followed by one transfer per cut piece; the final transfer has last set.
// Fill: each row i scans its candidate lengths 1..i, then drains the compare
// stage and writes the row; the single read port of the price and best
// memories delivers one candidate per cycle to the add and compare stage.
// Each emitted result then takes one memory read and one output load. A solve
// of length 0 sends only the total 0.
// Stalls: results sit in one output register; while the receiver holds ready
// low the walk waits, and the next request is taken as soon as the last
// result is loaded. Reset clears every price to zero at once and leaves the
// block ready for requests.
// ----------------------------------------------------------------------------
module rod_cutting_max_value #(
	parameter int MAX_LEN = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rcmv_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rcmv_pkg::rsp_t  rsp
);
	import rcmv_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencer.
	rcmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Tables and arithmetic.
	rcmv_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: design/rcmv_ctrl.sv
// ----------------------------------------------------------------------------
// rcmv_ctrl: sequencing state machine
// Steps the table fill row by row, then emits the total and the cut pieces,
// waiting on the output register whenever the receiver stalls.
// ----------------------------------------------------------------------------
module rcmv_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_op,
	output logic                   req_ready,
	input  rcmv_pkg::dp_status_t   status,
	output rcmv_pkg::ctrl_cmd_t    cmd
);
	import rcmv_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid && req_op == OP_SOLVE) begin
					state_d = status.req_zero ? S_VAL_RD : S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.j_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_WRITE;
			S_WRITE: begin
				state_d = status.i_last ? S_VAL_RD : S_SCAN;
			end
			S_VAL_RD: state_d = S_VAL_EMIT;
			S_VAL_EMIT: begin
				if (status.out_free) begin
					state_d = status.n_zero ? S_IDLE : S_CUT_RD;
				end
			end
			S_CUT_RD: state_d = S_CUT_EMIT;
			S_CUT_EMIT: begin
				if (status.out_free) begin
					state_d = status.rem_last ? S_IDLE : S_CUT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready      = 1'b1;
				cmd.load_price = req_valid && req_op == OP_LOAD;
				cmd.start      = req_valid && req_op == OP_SOLVE;
			end
			S_SCAN:     cmd.scan_issue = 1'b1;
			S_DRAIN:    cmd            = '0;
			S_WRITE:    cmd.row_write  = 1'b1;
			S_VAL_RD:   cmd.val_read   = 1'b1;
			S_VAL_EMIT: cmd.val_emit   = status.out_free;
			S_CUT_RD:   cmd.cut_read   = 1'b1;
			S_CUT_EMIT: cmd.cut_emit   = status.out_free;
			default:    cmd            = '0;
		endcase
	end

	// A solve transfer always leads straight into the fill or the total read.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_SCAN || state_q == S_VAL_RD))
		else $error("solve start did not enter fill or total read");

endmodule

FILE: design/rcmv_dp.sv
// ----------------------------------------------------------------------------
// rcmv_dp: tables, row scan and result register
// Holds the price, best and cut memories, the pipelined add and compare
// of one candidate per cycle, the walk down the cut table, and the output
// register.
// ----------------------------------------------------------------------------
module rcmv_dp #(
	parameter int MAX_LEN = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rcmv_pkg::req_t        req,
	input  logic                  rsp_ready,
	output logic                  rsp_valid,
	output rcmv_pkg::rsp_t        rsp,
	input  rcmv_pkg::ctrl_cmd_t   cmd,
	output rcmv_pkg::dp_status_t  status
);
	import rcmv_pkg::*;

	localparam int DEPTH = MAX_LEN + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

	logic [PRICE_W-1:0] price_mem [0:DEPTH-1];
	logic [DEPTH-1:0]   price_vld_q;
	logic [VALUE_W-1:0] best_mem [0:DEPTH-1];
	logic [AW-1:0]      cut_mem [0:DEPTH-1];

	logic [PRICE_W-1:0] price_rd_q;
	logic [VALUE_W-1:0] best_rd_q;
	logic [AW-1:0]      cut_rd_q;

	logic [AW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] rem_q;

	logic          cmp_vld_s1;
	logic          first_s1;
	logic [AW-1:0] j_s1;
	logic [SUM_W-1:0] top_q;
	logic [AW-1:0]    pick_q;

	logic             rsp_vld_q;
	rsp_t             rsp_q;

	logic [AW-1:0]    n_sat;
	logic [AW-1:0]    best_addr;
	logic [SUM_W-1:0] cand;
	logic [AW-1:0]    piece;
	logic             load_ok;

	// Rod length saturated to the table size; load range check.
	assign n_sat   = (req.length > MAX_LEN_L) ? AW'(MAX_LEN) : req.length[AW-1:0];
	assign load_ok = req.length <= MAX_LEN_L;

	// Price table: entries read as zero until loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_vld_q <= '0;
		end else if (cmd.load_price && load_ok) begin
			price_vld_q[req.length[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_price && load_ok) begin
			price_mem[req.length[AW-1:0]] <= req.price;
		end
		if (cmd.scan_issue) begin
			price_rd_q <= price_vld_q[j_q] ? price_mem[j_q] : '0;
		end
	end

	// Best table: entry 0 is the empty rod and always reads as zero.
	assign best_addr = cmd.val_read ? n_q : (i_q - j_q);

	always_ff @(posedge clk) begin
		if (cmd.row_write) begin
			best_mem[i_q] <= top_q[VALUE_W-1:0];
		end
		if (cmd.scan_issue || cmd.val_read) begin
			best_rd_q <= (best_addr == '0) ? '0 : best_mem[best_addr];
		end
	end

	// Cut table: first piece length that reaches each row's maximum.
	always_ff @(posedge clk) begin
		if (cmd.row_write) begin
			cut_mem[i_q] <= pick_q;
		end
		if (cmd.cut_read) begin
			cut_rd_q <= cut_mem[rem_q];
		end
	end

	// Row and column counters, and the remaining rod during the walk.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q <= n_sat;
			i_q <= AW'(1);
			j_q <= AW'(1);
		end else if (cmd.row_write) begin
			i_q <= i_q + AW'(1);
			j_q <= AW'(1);
		end else if (cmd.scan_issue) begin
			j_q <= j_q + AW'(1);
		end
		if (cmd.val_emit) begin
			rem_q <= n_q;
		end else if (cmd.cut_emit) begin
			rem_q <= rem_q - piece;
		end
	end

	// Compare stage: one candidate a cycle, in the cycle after the reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			first_s1 <= (j_q == AW'(1));
			j_s1     <= j_q;
		end
	end

	assign cand = SUM_W'(price_rd_q) + SUM_W'(best_rd_q);

	// Strictly greater keeps the first length that reaches the maximum.
	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && (first_s1 || cand > top_q)) begin
			top_q  <= cand;
			pick_q <= j_s1;
		end
	end

	// Piece of the walk: a stored cut that does not fit takes the whole rest.
	assign piece = (cut_rd_q == '0 || cut_rd_q > rem_q) ? rem_q : cut_rd_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmd.val_emit || cmd.cut_emit) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.val_emit) begin
			rsp_q.kind  <= KIND_TOTAL;
			rsp_q.value <= best_rd_q;
			rsp_q.last  <= (n_q == '0);
		end else if (cmd.cut_emit) begin
			rsp_q.kind  <= KIND_PIECE;
			rsp_q.value <= VALUE_W'(piece);
			rsp_q.last  <= (piece == rem_q);
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Status back to the controller.
	assign status.req_zero = (req.length == '0);
	assign status.j_last   = (j_q == i_q);
	assign status.i_last   = (i_q == n_q);
	assign status.n_zero   = (n_q == '0);
	assign status.rem_last = (piece == rem_q);
	assign status.out_free = !rsp_vld_q || rsp_ready;

	// The last candidate of a row is compared before the row is stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_write |-> !cmp_vld_s1)
		else $error("row stored while a compare was still in flight");

	// Every emitted piece is at least one and never longer than the rest.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cut_emit |-> (piece != '0 && piece <= rem_q))
		else $error("cut piece out of range");

	// A new result is loaded only into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.val_emit || cmd.cut_emit) |-> (!rsp_vld_q || rsp_ready))
		else $error("result overwrote one not yet taken");

endmodule
